[rtl/tgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg: shared codes for the touch gesture recognizer
// Input modes, result event codes, register indexes and fixed defaults.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // kind of input beat, carried on s_tuser
    typedef enum logic [1:0] {
        MODE_DOWN = 2'd0,
        MODE_UP   = 2'd1,
        MODE_MOVE = 2'd2,
        MODE_TICK = 2'd3
    } mode_t;

    // kind of result beat, carried on m_tuser[2:0]
    typedef enum logic [2:0] {
        EV_DOWN        = 3'd0,
        EV_SECOND_DOWN = 3'd1,
        EV_TAP         = 3'd2,
        EV_UP          = 3'd3,
        EV_SECOND_UP   = 3'd4,
        EV_MOVE        = 3'd5,
        EV_ZOOM        = 3'd6,
        EV_LONG_PRESS  = 3'd7
    } event_t;

    // configuration register index, paddr[4:2]
    typedef enum logic [2:0] {
        REG_LEFT       = 3'd0,
        REG_TOP        = 3'd1,
        REG_RIGHT      = 3'd2,
        REG_BOTTOM     = 3'd3,
        REG_TAP_TICKS  = 3'd4,
        REG_LONG_TICKS = 3'd5,
        REG_TAP_RADIUS = 3'd6,
        REG_LONG_RADIUS = 3'd7
    } reg_idx_t;

    localparam int ADDR_W = 5;
    localparam int PDATA_W = 32;

    // default tick thresholds
    localparam int TAP_TICKS_DEF  = 10;
    localparam int LONG_TICKS_DEF = 40;

    // default radii as hundredths of the full coordinate range
    localparam int TAP_RADIUS_PCT  = 5;
    localparam int LONG_RADIUS_PCT = 8;

endpackage

[rtl/touch_gesture_recognizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_recognizer: one- and two-finger gesture recognizer
// Tracks a primary and a secondary finger inside a region and reports down,
// tap, up, move, zoom and long-press beats from pointer events and ticks.
// ----------------------------------------------------------------------------
// Steps: down, second down, second up and one-finger move go from decode to
//   the result; primary up and long press square radius and anchor distance
//   first; a two-finger move runs the squarer and the root twice.
// Throughput: one beat in flight; the next beat is taken once the last result
//   loads (held while the output stalls) or a beat without a result ends.
// Reset: synchronous active-low aresetn clears fingers, ticks and handshakes.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer #(
    parameter int COORD_BITS = 12,
    parameter int COUNT_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input beats
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata, low to high: pointer_id, pos_x, pos_y
    input  logic [((5+2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // s_tuser: mode
    input  logic [1:0]                             s_tuser,
    // result beats
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata, low to high: event_x, event_y, delta_x, delta_y, zoom_change
    output logic [((5*COORD_BITS+4+7)/8)*8-1:0]    m_tdata,
    // m_tuser, low to high: event_code, claimed
    output logic [3:0]                             m_tuser,
    output logic                                   m_tlast,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tgr_pkg::ADDR_W-1:0]             paddr,
    input  logic [tgr_pkg::PDATA_W-1:0]            pwdata,
    output logic [tgr_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);

    import tgr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int K      = COUNT_BITS;
    localparam int OUT_DW = ((5*C+4+7)/8)*8;
    localparam logic [C-1:0] TAP_R_DEF  = C'(((2**C)*TAP_RADIUS_PCT + 50) / 100);
    localparam logic [C-1:0] LONG_R_DEF = C'(((2**C)*LONG_RADIUS_PCT + 50) / 100);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RAD,
        ST_RAD_W,
        ST_DIST,
        ST_DIST_W,
        ST_ZD,
        ST_ZD_W,
        ST_ZS_W,
        ST_EMIT
    } state_t;

    // configuration registers
    logic [C-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [K-1:0] tap_ticks_reg, long_ticks_reg;
    logic [C-1:0] tap_r_reg, long_r_reg;

    // controller
    state_t       state_reg;
    mode_t        op_mode_reg;
    logic [4:0]   op_id_reg;
    logic [C-1:0] op_x_reg, op_y_reg;

    logic         prim_act_reg, sec_act_reg;
    logic [4:0]   prim_id_reg, sec_id_reg;
    logic [C-1:0] prim_x_reg, prim_y_reg;
    logic [C-1:0] anch_x_reg, anch_y_reg;
    logic [C-1:0] sec_x_reg, sec_y_reg;
    logic [K-1:0] tick_reg;

    logic [2*C:0] r2_reg;
    logic [C:0]   old_root_reg;
    logic         zoom_pass_reg;

    event_t       res_code_reg [3];
    logic [1:0]   res_num_reg;
    logic [1:0]   res_idx_reg;
    logic [C-1:0] ev_x_reg, ev_y_reg;
    logic signed [C:0]   ev_dx_reg, ev_dy_reg;
    logic signed [C+1:0] ev_zoom_reg;
    logic         ev_claimed_reg;

    logic              m_tvalid_reg;
    logic [OUT_DW-1:0] m_tdata_reg;
    logic [3:0]        m_tuser_reg;
    logic              m_tlast_reg;

    // datapath links
    logic         dsq_start, dsq_done;
    logic [C-1:0] dsq_ax, dsq_ay, dsq_bx, dsq_by;
    logic [2*C:0] dsq_sum;
    logic         sqrt_start, sqrt_done;
    logic [C:0]   sqrt_root;

    logic         cfg_wr;
    logic [4:0]   in_id;
    logic [C-1:0] in_x, in_y;
    logic         prim_hit, sec_hit, in_region, tap_ok;
    logic [K-1:0] tick_inc;
    logic         out_free, emit_last;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= '0;
            top_reg        <= '0;
            right_reg      <= '1;
            bottom_reg     <= '1;
            tap_ticks_reg  <= K'(TAP_TICKS_DEF);
            long_ticks_reg <= K'(LONG_TICKS_DEF);
            tap_r_reg      <= TAP_R_DEF;
            long_r_reg     <= LONG_R_DEF;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_LEFT:        left_reg       <= pwdata[C-1:0];
                REG_TOP:         top_reg        <= pwdata[C-1:0];
                REG_RIGHT:       right_reg      <= pwdata[C-1:0];
                REG_BOTTOM:      bottom_reg     <= pwdata[C-1:0];
                REG_TAP_TICKS:   tap_ticks_reg  <= pwdata[K-1:0];
                REG_LONG_TICKS:  long_ticks_reg <= pwdata[K-1:0];
                REG_TAP_RADIUS:  tap_r_reg      <= pwdata[C-1:0];
                REG_LONG_RADIUS: long_r_reg     <= pwdata[C-1:0];
            endcase
        end
    end

    // read back the addressed register
    always_comb begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_LEFT:        prdata = PDATA_W'(left_reg);
            REG_TOP:         prdata = PDATA_W'(top_reg);
            REG_RIGHT:       prdata = PDATA_W'(right_reg);
            REG_BOTTOM:      prdata = PDATA_W'(bottom_reg);
            REG_TAP_TICKS:   prdata = PDATA_W'(tap_ticks_reg);
            REG_LONG_TICKS:  prdata = PDATA_W'(long_ticks_reg);
            REG_TAP_RADIUS:  prdata = PDATA_W'(tap_r_reg);
            REG_LONG_RADIUS: prdata = PDATA_W'(long_r_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // serial arithmetic units
    // ------------------------------------------------------------------
    tgr_dsq #(.COORD_BITS(C)) u_dsq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dsq_start),
        .ax      (dsq_ax),
        .ay      (dsq_ay),
        .bx      (dsq_bx),
        .by      (dsq_by),
        .done    (dsq_done),
        .sum     (dsq_sum)
    );

    tgr_isqrt #(.COORD_BITS(C)) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (dsq_sum),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // pick squarer operands by step: radius, anchor distance, separation
    always_comb begin
        dsq_start = 1'b0;
        dsq_ax    = prim_x_reg;
        dsq_ay    = prim_y_reg;
        dsq_bx    = sec_x_reg;
        dsq_by    = sec_y_reg;
        unique case (state_reg)
            ST_RAD: begin
                dsq_start = 1'b1;
                dsq_ax    = (op_mode_reg == MODE_UP) ? tap_r_reg : long_r_reg;
                dsq_ay    = '0;
                dsq_bx    = '0;
                dsq_by    = '0;
            end
            ST_DIST: begin
                dsq_start = 1'b1;
                dsq_bx    = anch_x_reg;
                dsq_by    = anch_y_reg;
            end
            ST_ZD: begin
                dsq_start = 1'b1;
            end
            default: begin
                dsq_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (state_reg == ST_ZD_W) && dsq_done;

    // ------------------------------------------------------------------
    // decode helpers
    // ------------------------------------------------------------------
    assign in_id = s_tdata[4:0];
    assign in_x  = s_tdata[5 +: C];
    assign in_y  = s_tdata[5+C +: C];

    assign prim_hit  = prim_act_reg && (op_id_reg == prim_id_reg);
    assign sec_hit   = sec_act_reg && (op_id_reg == sec_id_reg);
    assign in_region = (op_x_reg >= left_reg) && (op_x_reg <= right_reg) &&
                       (op_y_reg >= top_reg) && (op_y_reg <= bottom_reg);
    assign tick_inc  = tick_reg + K'(1);
    assign tap_ok    = (tick_reg < tap_ticks_reg) && (dsq_sum < r2_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = (res_idx_reg == (res_num_reg - 2'd1));

    // ------------------------------------------------------------------
    // controller: gesture state, step sequencing and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prim_act_reg  <= 1'b0;
            sec_act_reg   <= 1'b0;
            prim_id_reg   <= '0;
            sec_id_reg    <= '0;
            prim_x_reg    <= '0;
            prim_y_reg    <= '0;
            anch_x_reg    <= '0;
            anch_y_reg    <= '0;
            sec_x_reg     <= '0;
            sec_y_reg     <= '0;
            tick_reg      <= '0;
            zoom_pass_reg <= 1'b0;
            res_num_reg   <= '0;
            res_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // drop the result once taken, unless a new beat loads behind it
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_mode_reg <= mode_t'(s_tuser);
                        op_id_reg   <= in_id;
                        op_x_reg    <= in_x;
                        op_y_reg    <= in_y;
                        state_reg   <= ST_DECODE;
                    end
                end

                ST_DECODE: begin
                    res_idx_reg    <= '0;
                    res_num_reg    <= 2'd1;
                    ev_x_reg       <= op_x_reg;
                    ev_y_reg       <= op_y_reg;
                    ev_dx_reg      <= '0;
                    ev_dy_reg      <= '0;
                    ev_zoom_reg    <= '0;
                    ev_claimed_reg <= 1'b0;
                    state_reg      <= ST_IDLE;
                    unique case (op_mode_reg)
                        MODE_DOWN: begin
                            if (in_region) begin
                                state_reg <= ST_EMIT;
                                if (!prim_act_reg) begin
                                    prim_act_reg    <= 1'b1;
                                    prim_id_reg     <= op_id_reg;
                                    prim_x_reg      <= op_x_reg;
                                    prim_y_reg      <= op_y_reg;
                                    anch_x_reg      <= op_x_reg;
                                    anch_y_reg      <= op_y_reg;
                                    tick_reg        <= '0;
                                    res_code_reg[0] <= EV_DOWN;
                                    ev_claimed_reg  <= 1'b1;
                                end else begin
                                    sec_act_reg     <= 1'b1;
                                    sec_id_reg      <= op_id_reg;
                                    sec_x_reg       <= op_x_reg;
                                    sec_y_reg       <= op_y_reg;
                                    res_code_reg[0] <= EV_SECOND_DOWN;
                                end
                            end
                        end
                        MODE_UP: begin
                            if (prim_hit) begin
                                // tap test runs on the serial squarer
                                prim_act_reg   <= 1'b0;
                                sec_act_reg    <= 1'b0;
                                ev_x_reg       <= prim_x_reg;
                                ev_y_reg       <= prim_y_reg;
                                ev_claimed_reg <= 1'b1;
                                state_reg      <= ST_RAD;
                            end else if (sec_hit) begin
                                sec_act_reg     <= 1'b0;
                                res_code_reg[0] <= EV_SECOND_UP;
                                ev_claimed_reg  <= 1'b1;
                                state_reg       <= ST_EMIT;
                            end
                        end
                        MODE_MOVE: begin
                            if (prim_hit && !sec_act_reg) begin
                                ev_dx_reg <= $signed({1'b0, prim_x_reg}) -
                                             $signed({1'b0, op_x_reg});
                                ev_dy_reg <= $signed({1'b0, prim_y_reg}) -
                                             $signed({1'b0, op_y_reg});
                                prim_x_reg      <= op_x_reg;
                                prim_y_reg      <= op_y_reg;
                                res_code_reg[0] <= EV_MOVE;
                                ev_claimed_reg  <= 1'b1;
                                state_reg       <= ST_EMIT;
                            end else if (prim_hit || sec_hit) begin
                                // separation before and after the move
                                zoom_pass_reg <= 1'b0;
                                ev_x_reg      <= '0;
                                ev_y_reg      <= '0;
                                state_reg     <= ST_ZD;
                            end
                        end
                        MODE_TICK: begin
                            if (tick_reg != '1) begin
                                tick_reg <= tick_inc;
                                if (prim_act_reg && !sec_act_reg &&
                                    tick_inc == long_ticks_reg) begin
                                    ev_x_reg  <= prim_x_reg;
                                    ev_y_reg  <= prim_y_reg;
                                    state_reg <= ST_RAD;
                                end
                            end
                        end
                    endcase
                end

                ST_RAD: begin
                    state_reg <= ST_RAD_W;
                end

                ST_RAD_W: begin
                    if (dsq_done) begin
                        r2_reg    <= dsq_sum;
                        state_reg <= ST_DIST;
                    end
                end

                ST_DIST: begin
                    state_reg <= ST_DIST_W;
                end

                ST_DIST_W: begin
                    if (dsq_done) begin
                        if (op_mode_reg == MODE_UP) begin
                            state_reg <= ST_EMIT;
                            if (tap_ok) begin
                                res_code_reg[0] <= EV_TAP;
                                res_code_reg[1] <= EV_UP;
                                res_code_reg[2] <= EV_SECOND_UP;
                                res_num_reg     <= 2'd3;
                            end else begin
                                res_code_reg[0] <= EV_UP;
                                res_code_reg[1] <= EV_SECOND_UP;
                                res_num_reg     <= 2'd2;
                            end
                        end else if (dsq_sum < r2_reg) begin
                            res_code_reg[0] <= EV_LONG_PRESS;
                            state_reg       <= ST_EMIT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_ZD: begin
                    state_reg <= ST_ZD_W;
                end

                ST_ZD_W: begin
                    if (dsq_done) begin
                        state_reg <= ST_ZS_W;
                    end
                end

                ST_ZS_W: begin
                    if (sqrt_done) begin
                        if (!zoom_pass_reg) begin
                            // hold the old separation, move the finger
                            old_root_reg  <= sqrt_root;
                            zoom_pass_reg <= 1'b1;
                            if (prim_hit) begin
                                prim_x_reg <= op_x_reg;
                                prim_y_reg <= op_y_reg;
                            end else begin
                                sec_x_reg <= op_x_reg;
                                sec_y_reg <= op_y_reg;
                            end
                            state_reg <= ST_ZD;
                        end else begin
                            ev_zoom_reg <= $signed({1'b0, sqrt_root}) -
                                           $signed({1'b0, old_root_reg});
                            res_code_reg[0] <= EV_ZOOM;
                            state_reg       <= ST_EMIT;
                        end
                    end
                end

                ST_EMIT: begin
                    // load one result beat when the output register frees
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_DW'({ev_zoom_reg, ev_dy_reg, ev_dx_reg,
                                                 ev_y_reg, ev_x_reg});
                        m_tuser_reg  <= {ev_claimed_reg, res_code_reg[res_idx_reg]};
                        m_tlast_reg  <= emit_last;
                        res_idx_reg  <= res_idx_reg + 2'd1;
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/tgr_dsq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_dsq: bit-serial squared distance
// Computes (ax-bx)^2 + (ay-by)^2 by shift-and-add, one multiplier bit per
// cycle, the x pass first, then the y pass.
// ----------------------------------------------------------------------------
module tgr_dsq #(
    parameter int COORD_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [COORD_BITS-1:0]   ax,
    input  logic [COORD_BITS-1:0]   ay,
    input  logic [COORD_BITS-1:0]   bx,
    input  logic [COORD_BITS-1:0]   by,
    output logic                    done,
    output logic [2*COORD_BITS:0]   sum
);

    localparam int C     = COORD_BITS;
    localparam int CNT_W = $clog2(C);

    logic             busy_reg;
    logic             done_reg;
    logic             phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [2*C-1:0]   mcand_reg;
    logic [C-1:0]     mplier_reg;
    logic [C-1:0]     ady_reg;
    logic [2*C:0]     acc_reg;

    logic [C-1:0]     adx;
    logic [C-1:0]     ady;
    logic [2*C:0]     acc_next;

    // absolute coordinate differences
    assign adx = (ax >= bx) ? (ax - bx) : (bx - ax);
    assign ady = (ay >= by) ? (ay - by) : (by - ay);

    // add the shifted multiplicand when the current multiplier bit is set
    assign acc_next = mplier_reg[0] ? (acc_reg + {1'b0, mcand_reg}) : acc_reg;

    // run the x pass, then the y pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                phase_reg  <= 1'b0;
                cnt_reg    <= '0;
                mcand_reg  <= (2*C)'(adx);
                mplier_reg <= adx;
                ady_reg    <= ady;
                acc_reg    <= '0;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                if (cnt_reg == CNT_W'(C - 1)) begin
                    cnt_reg <= '0;
                    if (!phase_reg) begin
                        phase_reg  <= 1'b1;
                        mcand_reg  <= (2*C)'(ady_reg);
                        mplier_reg <= ady_reg;
                    end else begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end else begin
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    mcand_reg  <= {mcand_reg[2*C-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[C-1:1]};
                end
            end
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

[rtl/tgr_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_isqrt: digit-serial floor square root
// Restoring root extraction, one radix-4 digit of the radicand per cycle.
// ----------------------------------------------------------------------------
module tgr_isqrt #(
    parameter int COORD_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [2*COORD_BITS:0]   value,
    output logic                    done,
    output logic [COORD_BITS:0]     root
);

    localparam int C     = COORD_BITS;
    localparam int N     = C + 1;
    localparam int SW    = 2 * N;
    localparam int CNT_W = $clog2(N);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SW-1:0]    src_reg;
    logic [C+1:0]     rem_reg;
    logic [C:0]       root_reg;

    logic [C+3:0]     rem_sh;
    logic [C+2:0]     trial;
    logic             fits;
    logic [C+3:0]     rem_dif;

    // bring down the next digit and try root*4+1
    assign rem_sh  = {rem_reg, src_reg[SW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign fits    = rem_sh >= {1'b0, trial};
    assign rem_dif = rem_sh - {1'b0, trial};

    // one root bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                src_reg  <= SW'(value);
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                src_reg <= {src_reg[SW-3:0], 2'b00};
                if (fits) begin
                    rem_reg  <= rem_dif[C+1:0];
                    root_reg <= {root_reg[C-1:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh[C+1:0];
                    root_reg <= {root_reg[C-1:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/tgr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_checker: port-level checks for the touch gesture recognizer
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module tgr_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((5*COORD_BITS+4+7)/8)*8-1:0]   m_tdata,
    input logic [3:0]                            m_tuser,
    input logic                                  m_tlast
);

    import tgr_pkg::*;

    localparam int C = COORD_BITS;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // one input beat at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // a tap never closes its run (up and second up follow it)
    a_tap_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == EV_TAP) |-> !m_tlast)
        else $error("tap closed a run");

    // zoom carries no position and is never claimed
    a_zoom_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == EV_ZOOM) |->
            (m_tdata[2*C-1:0] == '0) && !m_tuser[3] && m_tlast)
        else $error("bad zoom beat");

    // a one-finger move is claimed and stands alone
    a_move_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == EV_MOVE) |-> m_tuser[3] && m_tlast)
        else $error("bad move beat");

endmodule

bind touch_gesture_recognizer tgr_checker #(.COORD_BITS(COORD_BITS)) u_tgr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for touch_gesture_recognizer
// Drives pointer and tick beats with random gaps, writes the region and
// threshold registers between phases, and checks every result beat against
// a gesture tracker that keeps its own copy of the finger state.
// ----------------------------------------------------------------------------
module testbench;
    import tgr_pkg::*;

    // one expected result beat
    typedef struct {
        event_t           code;
        bit [11:0]        ex;
        bit [11:0]        ey;
        bit signed [12:0] dx;
        bit signed [12:0] dy;
        bit signed [13:0] zoom;
        bit               claimed;
        bit               last;
    } gesture_event_t;

    // finger tracker and store of awaited gesture events
    class gesture_board;
        bit [11:0] left_edge, top_edge, right_edge, bottom_edge;
        bit [7:0]  tap_limit, long_ticks;
        bit [11:0] tap_radius, long_radius;
        bit        prim_on, sec_on;
        bit [4:0]  prim_id, sec_id;
        bit [11:0] prim_x, prim_y, anch_x, anch_y, sec_x, sec_y;
        bit [7:0]  ticks;
        gesture_event_t awaited[$];
        int errors;
        int checked;

        function new();
            right_edge  = 12'd4095;
            bottom_edge = 12'd4095;
            tap_limit   = 8'(TAP_TICKS_DEF);
            long_ticks  = 8'(LONG_TICKS_DEF);
            tap_radius  = 12'd205;
            long_radius = 12'd328;
        endfunction

        function void set_reg(reg_idx_t idx, bit [31:0] v);
            case (idx)
                REG_LEFT:        left_edge   = v[11:0];
                REG_TOP:         top_edge    = v[11:0];
                REG_RIGHT:       right_edge  = v[11:0];
                REG_BOTTOM:      bottom_edge = v[11:0];
                REG_TAP_TICKS:   tap_limit   = v[7:0];
                REG_LONG_TICKS:  long_ticks  = v[7:0];
                REG_TAP_RADIUS:  tap_radius  = v[11:0];
                REG_LONG_RADIUS: long_radius = v[11:0];
            endcase
        endfunction

        function longint unsigned sep_sq(bit [11:0] ax, bit [11:0] ay,
                                         bit [11:0] bx, bit [11:0] by);
            longint dx;
            longint dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            return dx * dx + dy * dy;
        endfunction

        // floor square root, one result bit per trial from the top
        function int floor_root(longint unsigned v);
            bit [15:0] r;
            bit [15:0] t;
            r = '0;
            for (int i = 15; i >= 0; i--) begin
                t = r | (16'd1 << i);
                if (longint'(t) * longint'(t) <= v) r = t;
            end
            return int'(r);
        endfunction

        function void push_event(event_t c, bit [11:0] x, bit [11:0] y,
                                 int dx, int dy, int zoom, bit cl);
            gesture_event_t e;
            e.code = c;
            e.ex = x;
            e.ey = y;
            e.dx = 13'(dx);
            e.dy = 13'(dy);
            e.zoom = 14'(zoom);
            e.claimed = cl;
            e.last = 1'b0;
            awaited.push_back(e);
        endfunction

        // advance the finger state by one accepted input beat
        function void note_input(mode_t m, bit [4:0] id, bit [11:0] x, bit [11:0] y);
            int  queued_n;
            int  old_d;
            int  new_d;
            bit  is_prim;
            queued_n = awaited.size();
            case (m)
                MODE_DOWN: begin
                    if (x >= left_edge && x <= right_edge &&
                        y >= top_edge && y <= bottom_edge) begin
                        if (!prim_on) begin
                            prim_on = 1;
                            prim_id = id;
                            prim_x = x;
                            prim_y = y;
                            anch_x = x;
                            anch_y = y;
                            ticks = 0;
                            push_event(EV_DOWN, x, y, 0, 0, 0, 1);
                        end else begin
                            sec_on = 1;
                            sec_id = id;
                            sec_x = x;
                            sec_y = y;
                            push_event(EV_SECOND_DOWN, x, y, 0, 0, 0, 0);
                        end
                    end
                end
                MODE_UP: begin
                    if (prim_on && id == prim_id) begin
                        if (ticks < tap_limit && sep_sq(anch_x, anch_y, prim_x, prim_y) <
                            longint'(tap_radius) * longint'(tap_radius))
                            push_event(EV_TAP, prim_x, prim_y, 0, 0, 0, 1);
                        push_event(EV_UP, prim_x, prim_y, 0, 0, 0, 1);
                        push_event(EV_SECOND_UP, prim_x, prim_y, 0, 0, 0, 1);
                        prim_on = 0;
                        sec_on = 0;
                    end else if (sec_on && id == sec_id) begin
                        sec_on = 0;
                        push_event(EV_SECOND_UP, x, y, 0, 0, 0, 1);
                    end
                end
                MODE_MOVE: begin
                    is_prim = prim_on && id == prim_id;
                    if (is_prim && !sec_on) begin
                        push_event(EV_MOVE, x, y, int'(prim_x) - int'(x),
                                   int'(prim_y) - int'(y), 0, 1);
                        prim_x = x;
                        prim_y = y;
                    end else if (sec_on && (is_prim || id == sec_id)) begin
                        old_d = floor_root(sep_sq(prim_x, prim_y, sec_x, sec_y));
                        if (is_prim) begin
                            prim_x = x;
                            prim_y = y;
                        end else begin
                            sec_x = x;
                            sec_y = y;
                        end
                        new_d = floor_root(sep_sq(prim_x, prim_y, sec_x, sec_y));
                        push_event(EV_ZOOM, 0, 0, 0, 0, new_d - old_d, 0);
                    end
                end
                MODE_TICK: begin
                    // long press only on the tick that reaches the threshold
                    if (ticks != 8'hFF) begin
                        ticks++;
                        if (prim_on && !sec_on && ticks == long_ticks &&
                            sep_sq(anch_x, anch_y, prim_x, prim_y) <
                            longint'(long_radius) * longint'(long_radius))
                            push_event(EV_LONG_PRESS, prim_x, prim_y, 0, 0, 0, 0);
                    end
                end
            endcase
            if (awaited.size() > queued_n) awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                $error("%s expected %0d got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // match one result beat against the oldest awaited event
        function void check_result(bit [63:0] d, bit [3:0] u, bit lst);
            gesture_event_t   e;
            bit signed [12:0] got_dx;
            bit signed [12:0] got_dy;
            bit signed [13:0] got_zoom;
            checked++;
            if (awaited.size() == 0) begin
                $error("result beat with no event awaited, event_code %0d", u[2:0]);
                errors++;
                return;
            end
            e = awaited.pop_front();
            got_dx = d[36:24];
            got_dy = d[49:37];
            got_zoom = d[63:50];
            compare_field("event_code", e.code, u[2:0]);
            compare_field("event_x", e.ex, d[11:0]);
            compare_field("event_y", e.ey, d[23:12]);
            compare_field("delta_x", e.dx, got_dx);
            compare_field("delta_y", e.dy, got_dy);
            compare_field("zoom_change", e.zoom, got_zoom);
            compare_field("claimed", e.claimed, u[3]);
            compare_field("last_of_run", e.last, lst);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata, low to high: pointer_id, pos_x, pos_y
    logic [31:0] s_tdata = '0;
    // s_tuser: mode
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata, low to high: event_x, event_y, delta_x, delta_y, zoom_change
    logic [63:0] m_tdata;
    // m_tuser, low to high: event_code, claimed
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    gesture_board board = new();
    int sent_items = 0;
    int settings_done = 0;
    bit tx_burst = 0;
    bit rx_burst = 0;
    int rx_hold = 0;
    bit squeeze_req = 0;

    touch_gesture_recognizer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // result side: check each beat, then stall for a drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            if (rx_hold == 0) m_tready <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tuser, m_tlast);
            if (board.checked % 32 == 0) rx_burst = ($urandom_range(0, 2) == 0);
            if (squeeze_req) begin
                // long hold-off so the block backs up into its input
                squeeze_req = 0;
                rx_hold = 400;
            end else begin
                rx_hold = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (rx_hold > 0) m_tready <= 1'b0;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end
    end

    // offer one input beat after a drawn gap and note it once accepted
    task automatic send_beat(mode_t m, bit [4:0] id, bit [11:0] x, bit [11:0] y);
        int gap;
        if (sent_items % 24 == 0) tx_burst = ($urandom_range(0, 2) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= m;
        s_tdata <= {3'b000, y, x, id};
        do @(posedge aclk); while (!s_tready);
        board.note_input(m, id, x, y);
        sent_items++;
    endtask

    // drop valid, wait for every awaited event, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // setup cycle then access cycle; psel stays up for back-to-back writes
    task automatic write_reg(reg_idx_t idx, bit [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(idx, v);
    endtask

    task automatic apply_settings(bit [31:0] cfg [8]);
        for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), cfg[i]);
        psel <= 1'b0;
        penable <= 1'b0;
        settings_done++;
    endtask

    function automatic bit [11:0] near_coord(bit [11:0] c, int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    // mostly well-formed gestures with random content, the rest noise
    task automatic run_gestures(int budget);
        int        stop_at;
        int        spread;
        bit [4:0]  pid;
        bit [4:0]  sid;
        bit [11:0] fx, fy, gx, gy;
        bit        two;
        stop_at = sent_items + budget;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                pid = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                                    5'($urandom_range(0, 3));
                fx = 12'($urandom_range(board.left_edge, board.right_edge));
                fy = 12'($urandom_range(board.top_edge, board.bottom_edge));
                spread = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 300);
                two = 0;
                send_beat(MODE_DOWN, pid, fx, fy);
                repeat ($urandom_range(0, 8)) begin
                    case ($urandom_range(0, 6))
                        0, 1: send_beat(MODE_TICK, 5'($urandom), 12'($urandom),
                                        12'($urandom));
                        2: begin
                            fx = near_coord(fx, spread);
                            fy = near_coord(fy, spread);
                            send_beat(MODE_MOVE, pid, fx, fy);
                        end
                        3: begin
                            if (!two) begin
                                sid = ($urandom_range(0, 4) == 0) ? pid :
                                                                    5'($urandom_range(4, 31));
                                gx = 12'($urandom_range(board.left_edge, board.right_edge));
                                gy = 12'($urandom_range(board.top_edge, board.bottom_edge));
                                two = 1;
                                send_beat(MODE_DOWN, sid, gx, gy);
                            end else begin
                                gx = near_coord(gx, 1000);
                                gy = near_coord(gy, 1000);
                                send_beat(MODE_MOVE, sid, gx, gy);
                            end
                        end
                        4: begin
                            if (two) begin
                                two = 0;
                                send_beat(MODE_UP, sid, gx, gy);
                            end else begin
                                send_beat(MODE_TICK, 5'($urandom), 12'($urandom),
                                          12'($urandom));
                            end
                        end
                        5: begin
                            if (two) begin
                                fx = near_coord(fx, 1000);
                                fy = near_coord(fy, 1000);
                            end
                            send_beat(MODE_MOVE, pid, fx, fy);
                        end
                        default: send_beat(mode_t'($urandom_range(0, 3)), 5'($urandom),
                                           12'($urandom), 12'($urandom));
                    endcase
                end
                // leave some presses open so the next down lands as a second finger
                if ($urandom_range(0, 7) != 0)
                    send_beat(MODE_UP, pid, 12'($urandom), 12'($urandom));
            end else begin
                send_beat(mode_t'($urandom_range(0, 3)), 5'($urandom), 12'($urandom),
                          12'($urandom));
            end
        end
    endtask

    initial begin
        int l, r, t, b;
        bit [31:0] cfg [8];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // default registers: tap, moves, second finger, zoom, unknown fingers
        send_beat(MODE_DOWN, 5'd3, 12'd100, 12'd100);
        send_beat(MODE_TICK, 5'd0, 12'd0, 12'd0);
        send_beat(MODE_MOVE, 5'd3, 12'd150, 12'd80);
        send_beat(MODE_UP, 5'd3, 12'd0, 12'd0);
        // distance equal to the tap radius is not a tap
        send_beat(MODE_DOWN, 5'd3, 12'd100, 12'd100);
        send_beat(MODE_MOVE, 5'd3, 12'd305, 12'd100);
        send_beat(MODE_UP, 5'd3, 12'd7, 12'd9);
        send_beat(MODE_DOWN, 5'd7, 12'd0, 12'd0);
        send_beat(MODE_DOWN, 5'd7, 12'd4095, 12'd4095);
        send_beat(MODE_MOVE, 5'd7, 12'd10, 12'd10);
        send_beat(MODE_DOWN, 5'd12, 12'd4095, 12'd0);
        send_beat(MODE_MOVE, 5'd12, 12'd2048, 12'd0);
        send_beat(MODE_MOVE, 5'd31, 12'd5, 12'd5);
        send_beat(MODE_UP, 5'd30, 12'd5, 12'd5);
        send_beat(MODE_UP, 5'd12, 12'd1, 12'd2);
        send_beat(MODE_MOVE, 5'd7, 12'd4095, 12'd4095);
        send_beat(MODE_MOVE, 5'd7, 12'd0, 12'd0);
        send_beat(MODE_UP, 5'd7, 12'd0, 12'd0);
        settle();

        // small region, short long press, no taps possible
        cfg = '{1000, 1000, 2000, 2000, 0, 2, 0, 4095};
        apply_settings(cfg);
        send_beat(MODE_DOWN, 5'd1, 12'd999, 12'd1500);
        send_beat(MODE_DOWN, 5'd1, 12'd1000, 12'd2000);
        send_beat(MODE_TICK, 5'd0, 12'd0, 12'd0);
        send_beat(MODE_TICK, 5'd0, 12'd0, 12'd0);
        send_beat(MODE_UP, 5'd1, 12'd0, 12'd0);
        settle();

        // empty region rejects every down; long press threshold of zero
        cfg = '{3000, 1000, 2000, 2000, 0, 0, 0, 4095};
        apply_settings(cfg);
        send_beat(MODE_DOWN, 5'd2, 12'd2500, 12'd1500);
        settle();
        cfg[REG_LEFT] = 1000;
        apply_settings(cfg);
        send_beat(MODE_DOWN, 5'd2, 12'd2000, 12'd1000);
        send_beat(MODE_TICK, 5'd0, 12'd0, 12'd0);
        send_beat(MODE_UP, 5'd2, 12'd0, 12'd0);
        settle();

        // random phases over several register settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: cfg = '{0, 0, 4095, 4095, TAP_TICKS_DEF, 3, 205, 328};
                1: cfg = '{0, 0, 4095, 4095, 255, 255, 4095, 4095};
                2: cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
                default: begin
                    l = $urandom_range(0, 4095);
                    r = $urandom_range(l, 4095);
                    t = $urandom_range(0, 4095);
                    b = $urandom_range(t, 4095);
                    cfg = '{l, t, r, b, $urandom_range(0, 12), $urandom_range(1, 6),
                            $urandom_range(0, 600), $urandom_range(0, 4095)};
                end
            endcase
            apply_settings(cfg);
            if (p == 1 || p == 4) squeeze_req = 1;
            run_gestures(45);
            settle();
        end

        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 sent_items, board.checked, settings_done);
        $display("included taps, long presses, zoom, empty regions and a backed-up output");
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
